FILE: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [VAL_W-1:0] GET_MISS_VALUE = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] PUT_VALUE      = {VAL_W{1'b0}};

  // register index of capacity_in_use
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic load;      // capture request, restart scan
    logic scan;      // read key at scan counter, advance
    logic exec;      // apply lookup outcome to the store
    logic get_val;   // capture read value for a get hit
    logic out_load;  // move result into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic get_hit;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/lkvc_ram.sv
// Generic simple dual-port RAM with registered read.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lkvc_ctrl.sv
// Request sequencer for the LRU key-value cache.
module lkvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lkvc_pkg::dp_sts_t   sts_i,
  output lkvc_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_GETV   = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.get_hit ? ST_GETV : ST_RESULT;
      end
      ST_GETV: begin
        cmd_o.get_val = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: rtl/lkvc_dp.sv
// Datapath: key/value RAMs, valid and recency cells, scan and result registers.
module lkvc_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lkvc_pkg::ctrl_cmd_t         cmd_i,
  output lkvc_pkg::dp_sts_t           sts_o,
  input  logic                        mode_i,
  input  logic [lkvc_pkg::KEY_W-1:0]  key_i,
  input  logic [lkvc_pkg::VAL_W-1:0]  value_i,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_hit_o,
  output logic [lkvc_pkg::VAL_W-1:0]  out_read_value_o,
  output logic                        out_evicted_o
);

  localparam int N  = MAX_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int EW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  // request
  logic                       mode_q;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] val_q;

  // scan
  logic [IW-1:0] cnt_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q;
  logic [IW-1:0] fidx_q;
  logic [IW-1:0] frank_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;
  logic [IW-1:0] lru_idx_q;

  // store state
  logic [N-1:0]  valid_q, valid_d;
  logic [IW-1:0] rank_q [N];
  logic [IW-1:0] rank_d [N];
  logic [CW-1:0] occ_q, occ_d;

  // result
  logic                       res_hit_q;
  logic                       res_ev_q;
  logic [lkvc_pkg::VAL_W-1:0] res_val_q;
  logic                       out_valid_q;
  logic                       out_hit_q;
  logic                       out_ev_q;
  logic [lkvc_pkg::VAL_W-1:0] out_val_q;

  logic [lkvc_pkg::KEY_W-1:0] key_rdata;
  logic [lkvc_pkg::VAL_W-1:0] val_rdata;

  logic          key_we;
  logic          val_we;
  logic [IW-1:0] val_waddr;

  logic [EW-1:0] eff_cap;
  logic          full;
  logic          evict;
  logic [IW-1:0] ins_slot;
  logic [N-1:0]  valid_kept;
  logic [CW-1:0] lru_rank;

  // effective capacity, saturated to 1..N
  always_comb begin
    eff_cap = EW'(capacity_i);
    if (capacity_i == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(capacity_i) > EW'(N)) begin
      eff_cap = EW'(N);
    end
  end

  assign full     = EW'(occ_q) >= eff_cap;
  assign evict    = full && (occ_q != '0);
  assign lru_rank = occ_q - CW'(1);

  always_comb begin
    valid_kept = valid_q;
    if (evict) begin
      valid_kept[lru_idx_q] = 1'b0;
    end
  end

  always_comb begin
    if (!evict) begin
      ins_slot = free_idx_q;
    end else if (free_q && (free_idx_q < lru_idx_q)) begin
      ins_slot = free_idx_q;
    end else begin
      ins_slot = lru_idx_q;
    end
  end

  assign key_we    = cmd_i.exec && (mode_q == lkvc_pkg::MODE_PUT) && !found_q;
  assign val_we    = cmd_i.exec && (mode_q == lkvc_pkg::MODE_PUT);
  assign val_waddr = found_q ? fidx_q : ins_slot;

  lkvc_ram #(
    .WIDTH (lkvc_pkg::KEY_W),
    .DEPTH (N)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (ins_slot),
    .wdata_i (key_q),
    .raddr_i (cnt_q),
    .rdata_o (key_rdata)
  );

  lkvc_ram #(
    .WIDTH (lkvc_pkg::VAL_W),
    .DEPTH (N)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .raddr_i (fidx_q),
    .rdata_o (val_rdata)
  );

  // valid and recency update
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.exec) begin
      if (found_q) begin
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == fidx_q) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < frank_q)) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
      end else if (mode_q == lkvc_pkg::MODE_PUT) begin
        for (int i = 0; i < N; i++) begin
          if (IW'(i) == ins_slot) begin
            rank_d[i] = '0;
          end else if (valid_kept[i]) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
        valid_d           = valid_kept;
        valid_d[ins_slot] = 1'b1;
        occ_d             = evict ? occ_q : occ_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan;
      cmp_idx_q <= cnt_q;
      if (cmd_i.load) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          cnt_q <= cnt_q + IW'(1);
        end
        if (cmp_vld_q && valid_q[cmp_idx_q] && (key_rdata == key_q)) begin
          found_q <= 1'b1;
        end
        if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
    if (cmp_vld_q && valid_q[cmp_idx_q] && (key_rdata == key_q)) begin
      fidx_q  <= cmp_idx_q;
      frank_q <= rank_q[cmp_idx_q];
    end
    if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmp_vld_q && valid_q[cmp_idx_q] && (CW'(rank_q[cmp_idx_q]) == lru_rank)) begin
      lru_idx_q <= cmp_idx_q;
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_hit_q <= found_q;
      res_ev_q  <= (mode_q == lkvc_pkg::MODE_PUT) && !found_q && evict;
      if (mode_q == lkvc_pkg::MODE_PUT) begin
        res_val_q <= lkvc_pkg::PUT_VALUE;
      end else begin
        res_val_q <= lkvc_pkg::GET_MISS_VALUE;
      end
    end
    if (cmd_i.get_val) begin
      res_val_q <= val_rdata;
    end
    if (cmd_i.out_load) begin
      out_hit_q <= res_hit_q;
      out_ev_q  <= res_ev_q;
      out_val_q <= res_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.scan_last = (cnt_q == IW'(N - 1));
  assign sts_o.get_hit   = (mode_q == lkvc_pkg::MODE_GET) && found_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_read_value_o = out_val_q;
  assign out_evicted_o    = out_ev_q;

endmodule

FILE: rtl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: stream ports, APB register, sequencer and datapath.
//
// Fully associative get/put cache with least-recently-used replacement over
// MAX_ENTRIES entries. Keys and values live in two RAMs; a request scans the
// key RAM one entry per cycle through its single read port. After the scan, the
// request passes a drain state and an execute state, then a get hit reads the
// value RAM, and the result waits in the result state for a free output
// register. One request is in flight at a time; the next one is accepted once
// the result sits in the output register. The capacity register (offset 0)
// limits how many entries are filled before eviction; 0 acts as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES. Write it only while the cache is idle.
module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic        s_axis_tuser,   // [0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] hit, [32:1] read_value, [33] evicted, [39:34] zero
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lkvc_pkg::ctrl_cmd_t cmd;
  lkvc_pkg::dp_sts_t   sts;

  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic                       reg_sel;
  logic                       out_hit;
  logic                       out_evicted;
  logic [lkvc_pkg::VAL_W-1:0] out_read_value;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lkvc_pkg::REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      cap_q <= pwdata[lkvc_pkg::CAP_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - lkvc_pkg::CAP_W){1'b0}}, cap_q} : 32'd0;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (s_axis_tuser),
    .key_i            (s_axis_tdata[31:0]),
    .value_i          (s_axis_tdata[63:32]),
    .capacity_i       (cap_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_hit_o        (out_hit),
    .out_read_value_o (out_read_value),
    .out_evicted_o    (out_evicted)
  );

  assign m_axis_tdata = {6'd0, out_evicted, out_read_value, out_hit};

endmodule
